// File: src/pthc_pkg.sv
// Shared types and constants for the humidity/pressure/temperature compensation unit.
// Used by pthc_div_pipe and pth_sensor_compensation_unit; depends on nothing.
`default_nettype none

package pthc_pkg;

   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;
   localparam int DIV_W        = 64;
   localparam int DEN_W        = 31;
   localparam int DIV_STEPS    = DIV_W;
   localparam int FRONT_STAGES = 11;
   localparam int BACK_STAGES  = 4;

   typedef enum logic [2:0] {
      REG_TEMP_TRIM    = 3'd0,
      REG_PRESS_TRIM_A = 3'd1,
      REG_PRESS_TRIM_B = 3'd2,
      REG_PRESS_TRIM_C = 3'd3,
      REG_HUM_TRIM     = 3'd4
   } csr_index_type;

   localparam logic [19:0]        TEMP_SKIP      = 20'h80000;
   localparam logic [19:0]        PRESS_SKIP     = 20'h80000;
   localparam logic [15:0]        HUM_SKIP       = 16'h8000;
   localparam logic signed [31:0] TEMP_ROUND     = 32'sd128;
   localparam logic signed [32:0] PRESS_T_OFFSET = 33'sd128000;
   localparam logic signed [31:0] HUM_T_OFFSET   = 32'sd76800;
   localparam logic [20:0]        PRESS_BASE     = 21'd1048576;
   localparam logic signed [63:0] PRESS_SCALE    = 64'sd3125;
   localparam logic signed [63:0] PRESS_X_BIAS   = 64'sh0000_8000_0000_0000;
   localparam logic [31:0]        HUM_ROUND      = 32'd16384;
   localparam logic signed [21:0] HUM_Y_BIAS     = 22'sd32768;
   localparam logic signed [22:0] HUM_Z_BIAS     = 23'sd2097152;
   localparam logic [31:0]        HUM_B_ROUND    = 32'd8192;
   localparam logic signed [31:0] HUM_CLAMP      = 32'sd419430400;
   localparam logic [16:0]        HUM_MAX        = 17'd102400;

   typedef struct packed {
      logic [31:0] temperature_centi;
      logic [16:0] humidity_q22_10;
      logic [2:0]  skipped_flags;
   } side_type;

   typedef struct packed {
      logic     neg;
      logic     zero;
      side_type side;
   } div_tag_type;

endpackage

`default_nettype wire

// File: src/pthc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// Depends on pthc_pkg for widths and the tag struct carried beside each item.
`default_nettype none

module pthc_div_pipe (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic [pthc_pkg::DIV_W-1:0] in_num,
   input  wire logic [pthc_pkg::DEN_W-1:0] in_den,
   input  pthc_pkg::div_tag_type           in_tag,
   output logic                           out_valid,
   output logic [pthc_pkg::DIV_W-1:0]     out_quo,
   output pthc_pkg::div_tag_type          out_tag
);
   import pthc_pkg::*;

   logic [DEN_W-1:0] rem_ff   [DIV_STEPS];
   logic [DEN_W-1:0] den_ff   [DIV_STEPS];
   logic [DIV_W-1:0] nq_ff    [DIV_STEPS];
   div_tag_type      tag_ff   [DIV_STEPS];
   logic             valid_ff [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [DEN_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [DIV_W-1:0] nq_prev;
      div_tag_type      tag_prev;
      logic             valid_prev;
      logic [DEN_W:0]   shifted;
      logic [DEN_W+1:0] diff;
      logic [DEN_W-1:0] rem_in;
      logic [DIV_W-1:0] nq_in;

      if (k == 0) begin : g_first
         assign rem_prev   = '0;
         assign den_prev   = in_den;
         assign nq_prev    = in_num;
         assign tag_prev   = in_tag;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign nq_prev    = nq_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         shifted = {rem_prev, nq_prev[DIV_W-1]};
         diff    = {1'b0, shifted} - {2'b00, den_prev};
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W-1:0];
         end else begin
            rem_in = shifted[DEN_W-1:0];
         end
         nq_in = {nq_prev[DIV_W-2:0], ~diff[DEN_W+1]};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            nq_ff[k]  <= nq_in;
            tag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quo   = nq_ff[DIV_STEPS-1];
   assign out_tag   = tag_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

// File: src/pth_sensor_compensation_unit.sv
// From item acceptance to rsp_valid: 11 front stages, 64 divider stages, 4 back
// stages, output register. Throughput: one item per cycle unless stalled.
// The 64-bit pressure quotient, one bit per stage, sets the depth of the pipeline.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Synchronous reset clears all valid bits and the trim registers to zero.
// Top level of the compensation unit; depends on pthc_pkg and pthc_div_pipe.
`default_nettype none

module pth_sensor_compensation_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [19:0]                    req_raw_temperature,
   input  wire logic [19:0]                    req_raw_pressure,
   input  wire logic [15:0]                    req_raw_humidity,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [31:0]                  rsp_temperature_centi,
   output logic [31:0]                         rsp_pressure_q24_8,
   output logic [16:0]                         rsp_humidity_q22_10,
   output logic [2:0]                          rsp_skipped_flags,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [pthc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [pthc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pthc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import pthc_pkg::*;

   // trim registers
   logic [47:0] temp_trim_ff;
   logic [63:0] press_trim_a_ff;
   logic [63:0] press_trim_b_ff;
   logic [15:0] press_trim_c_ff;
   logic [63:0] hum_trim_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff    <= '0;
         press_trim_a_ff <= '0;
         press_trim_b_ff <= '0;
         press_trim_c_ff <= '0;
         hum_trim_ff     <= '0;
      end else if (csr_write) begin
         case (csr_paddr[5:3])
            REG_TEMP_TRIM:    temp_trim_ff    <= csr_pwdata[47:0];
            REG_PRESS_TRIM_A: press_trim_a_ff <= csr_pwdata;
            REG_PRESS_TRIM_B: press_trim_b_ff <= csr_pwdata;
            REG_PRESS_TRIM_C: press_trim_c_ff <= csr_pwdata[15:0];
            REG_HUM_TRIM:     hum_trim_ff     <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[5:3])
         REG_TEMP_TRIM:    csr_prdata = {16'b0, temp_trim_ff};
         REG_PRESS_TRIM_A: csr_prdata = press_trim_a_ff;
         REG_PRESS_TRIM_B: csr_prdata = press_trim_b_ff;
         REG_PRESS_TRIM_C: csr_prdata = {48'b0, press_trim_c_ff};
         REG_HUM_TRIM:     csr_prdata = hum_trim_ff;
         default:          csr_prdata = '0;
      endcase
   end

   // trim fields
   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
   logic [7:0]         h1, h3;
   logic signed [15:0] h2;
   logic signed [11:0] h4, h5;
   logic signed [7:0]  h6;

   assign t1 = temp_trim_ff[15:0];
   assign t2 = temp_trim_ff[31:16];
   assign t3 = temp_trim_ff[47:32];
   assign p1 = press_trim_a_ff[15:0];
   assign p2 = press_trim_a_ff[31:16];
   assign p3 = press_trim_a_ff[47:32];
   assign p4 = press_trim_a_ff[63:48];
   assign p5 = press_trim_b_ff[15:0];
   assign p6 = press_trim_b_ff[31:16];
   assign p7 = press_trim_b_ff[47:32];
   assign p8 = press_trim_b_ff[63:48];
   assign p9 = press_trim_c_ff;
   assign h1 = hum_trim_ff[7:0];
   assign h2 = hum_trim_ff[23:8];
   assign h3 = hum_trim_ff[31:24];
   assign h4 = hum_trim_ff[43:32];
   assign h5 = hum_trim_ff[55:44];
   assign h6 = hum_trim_ff[63:56];

   // pipeline control
   logic                    pipe_en;
   logic                    req_accept;
   logic [FRONT_STAGES-1:0] front_valid_ff;
   logic [BACK_STAGES-1:0]  back_valid_ff;
   logic                    rsp_valid_ff;
   logic                    div_valid;

   assign pipe_en    = ~(rsp_valid_ff & rsp_stall);
   assign req_stall  = ~pipe_en;
   assign req_accept = req_valid & pipe_en;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
         back_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (pipe_en) begin
         front_valid_ff <= {front_valid_ff[FRONT_STAGES-2:0], req_valid};
         back_valid_ff  <= {back_valid_ff[BACK_STAGES-2:0], div_valid};
         rsp_valid_ff   <= back_valid_ff[BACK_STAGES-1];
      end
   end

   // stage 1: temperature differences and first products
   logic signed [18:0] d1;
   logic signed [17:0] d2;
   logic signed [34:0] s1_pa_in;
   logic signed [35:0] s1_pq_in;
   logic [2:0]         s1_flags_in;
   logic [34:0]        s1_pa_ff;
   logic [35:0]        s1_pq_ff;
   logic [19:0]        s1_rp_ff;
   logic [15:0]        s1_rh_ff;
   logic [2:0]         s1_flags_ff;

   always_comb begin
      d1 = $signed({2'b00, req_raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
      d2 = $signed({2'b00, req_raw_temperature[19:4]}) - $signed({2'b00, t1});
      s1_pa_in = d1 * t2;
      s1_pq_in = d2 * d2;
      s1_flags_in = {req_raw_humidity == HUM_SKIP, req_raw_pressure == PRESS_SKIP,
                     req_raw_temperature == TEMP_SKIP};
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_pa_ff    <= s1_pa_in;
         s1_pq_ff    <= s1_pq_in;
         s1_rp_ff    <= req_raw_pressure;
         s1_rh_ff    <= req_raw_humidity;
         s1_flags_ff <= s1_flags_in;
      end
   end

   // stage 2
   logic signed [19:0] sq;
   logic signed [35:0] s2_mb_in;
   logic [20:0]        s2_a_ff;
   logic [35:0]        s2_mb_ff;
   logic [19:0]        s2_rp_ff;
   logic [15:0]        s2_rh_ff;
   logic [2:0]         s2_flags_ff;

   always_comb begin
      sq       = s1_pq_ff[31:12];
      s2_mb_in = sq * t3;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_a_ff     <= s1_pa_ff[31:11];
         s2_mb_ff    <= s2_mb_in;
         s2_rp_ff    <= s1_rp_ff;
         s2_rh_ff    <= s1_rh_ff;
         s2_flags_ff <= s1_flags_ff;
      end
   end

   // stage 3: fine temperature
   logic [17:0]        bt;
   logic [31:0]        s3_tf_in;
   logic signed [31:0] s3_tf_ff;
   logic [19:0]        s3_rp_ff;
   logic [15:0]        s3_rh_ff;
   logic [2:0]         s3_flags_ff;

   always_comb begin
      bt       = s2_mb_ff[31:14];
      s3_tf_in = {{11{s2_a_ff[20]}}, s2_a_ff} + {{14{bt[17]}}, bt};
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_tf_ff    <= s3_tf_in;
         s3_rp_ff    <= s2_rp_ff;
         s3_rh_ff    <= s2_rh_ff;
         s3_flags_ff <= s2_flags_ff;
      end
   end

   // stage 4: offsets and temperature result
   logic signed [32:0] s4_x_in;
   logic signed [31:0] s4_hv_in;
   logic signed [31:0] t5;
   logic [31:0]        s4_tout_in;
   logic signed [32:0] s4_x_ff;
   logic signed [31:0] s4_hv_ff;
   logic [31:0]        s4_tout_ff;
   logic [19:0]        s4_rp_ff;
   logic [15:0]        s4_rh_ff;
   logic [2:0]         s4_flags_ff;

   always_comb begin
      s4_x_in  = {s3_tf_ff[31], s3_tf_ff} - PRESS_T_OFFSET;
      s4_hv_in = s3_tf_ff - HUM_T_OFFSET;
      t5       = (s3_tf_ff <<< 2) + s3_tf_ff + TEMP_ROUND;
      if (s3_flags_ff[0]) begin
         s4_tout_in = '0;
      end else begin
         s4_tout_in = t5 >>> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_x_ff     <= s4_x_in;
         s4_hv_ff    <= s4_hv_in;
         s4_tout_ff  <= s4_tout_in;
         s4_rp_ff    <= s3_rp_ff;
         s4_rh_ff    <= s3_rh_ff;
         s4_flags_ff <= s3_flags_ff;
      end
   end

   // stage 5: first pressure and humidity products
   logic signed [65:0] xx_full;
   logic signed [48:0] s5_xp5_in, s5_xp2_in;
   logic signed [43:0] h5v_full;
   logic signed [39:0] hv6_full;
   logic signed [40:0] hv3_full;
   logic signed [8:0]  h3s;
   logic [31:0]        s5_a0_in;
   logic signed [63:0] s5_xx_ff;
   logic signed [48:0] s5_xp5_ff, s5_xp2_ff;
   logic [31:0]        s5_h5v_ff, s5_hv6_ff, s5_hv3_ff, s5_a0_ff;
   logic [19:0]        s5_rp_ff;
   logic [31:0]        s5_tout_ff;
   logic [2:0]         s5_flags_ff;

   always_comb begin
      h3s       = $signed({1'b0, h3});
      xx_full   = s4_x_ff * s4_x_ff;
      s5_xp5_in = s4_x_ff * p5;
      s5_xp2_in = s4_x_ff * p2;
      h5v_full  = h5 * s4_hv_ff;
      hv6_full  = s4_hv_ff * h6;
      hv3_full  = s4_hv_ff * h3s;
      s5_a0_in  = {2'b00, s4_rh_ff, 14'b0} - {h4, 20'b0};
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_xx_ff    <= xx_full[63:0];
         s5_xp5_ff   <= s5_xp5_in;
         s5_xp2_ff   <= s5_xp2_in;
         s5_h5v_ff   <= h5v_full[31:0];
         s5_hv6_ff   <= hv6_full[31:0];
         s5_hv3_ff   <= hv3_full[31:0];
         s5_a0_ff    <= s5_a0_in;
         s5_rp_ff    <= s4_rp_ff;
         s5_tout_ff  <= s4_tout_ff;
         s5_flags_ff <= s4_flags_ff;
      end
   end

   // stage 6
   logic signed [63:0] s6_xxp6_in, s6_xxp3_in, s6_ypart_in, s6_xpart_in;
   logic signed [63:0] xp5_ext, xp2_ext, p4_ext;
   logic [31:0]        asum;
   logic signed [21:0] xh, yh;
   logic signed [43:0] mxy_full;
   logic signed [63:0] s6_xxp6_ff, s6_xxp3_ff, s6_ypart_ff, s6_xpart_ff;
   logic signed [16:0] s6_ha_ff;
   logic [31:0]        s6_mxy_ff;
   logic [19:0]        s6_rp_ff;
   logic [31:0]        s6_tout_ff;
   logic [2:0]         s6_flags_ff;

   always_comb begin
      s6_xxp6_in  = s5_xx_ff * p6;
      s6_xxp3_in  = s5_xx_ff * p3;
      xp5_ext     = {{15{s5_xp5_ff[48]}}, s5_xp5_ff};
      xp2_ext     = {{15{s5_xp2_ff[48]}}, s5_xp2_ff};
      p4_ext      = {{48{p4[15]}}, p4};
      s6_ypart_in = (xp5_ext <<< 17) + (p4_ext <<< 35);
      s6_xpart_in = (xp2_ext <<< 12) + PRESS_X_BIAS;
      asum        = s5_a0_ff - s5_h5v_ff + HUM_ROUND;
      xh          = s5_hv6_ff[31:10];
      yh          = $signed({s5_hv3_ff[31], s5_hv3_ff[31:11]}) + HUM_Y_BIAS;
      mxy_full    = xh * yh;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s6_xxp6_ff  <= s6_xxp6_in;
         s6_xxp3_ff  <= s6_xxp3_in;
         s6_ypart_ff <= s6_ypart_in;
         s6_xpart_ff <= s6_xpart_in;
         s6_ha_ff    <= asum[31:15];
         s6_mxy_ff   <= mxy_full[31:0];
         s6_rp_ff    <= s5_rp_ff;
         s6_tout_ff  <= s5_tout_ff;
         s6_flags_ff <= s5_flags_ff;
      end
   end

   // stage 7
   logic signed [63:0] s7_y_in, s7_v_in;
   logic signed [22:0] hz;
   logic signed [38:0] mz_full;
   logic signed [63:0] s7_y_ff, s7_v_ff;
   logic signed [16:0] s7_ha_ff;
   logic [31:0]        s7_mz_ff;
   logic [19:0]        s7_rp_ff;
   logic [31:0]        s7_tout_ff;
   logic [2:0]         s7_flags_ff;

   always_comb begin
      s7_y_in = s6_xxp6_ff + s6_ypart_ff;
      s7_v_in = (s6_xxp3_ff >>> 8) + s6_xpart_ff;
      hz      = $signed({s6_mxy_ff[31], s6_mxy_ff[31:10]}) + HUM_Z_BIAS;
      mz_full = hz * h2;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s7_y_ff     <= s7_y_in;
         s7_v_ff     <= s7_v_in;
         s7_ha_ff    <= s6_ha_ff;
         s7_mz_ff    <= mz_full[31:0];
         s7_rp_ff    <= s6_rp_ff;
         s7_tout_ff  <= s6_tout_ff;
         s7_flags_ff <= s6_flags_ff;
      end
   end

   // stage 8
   logic signed [63:0] s8_m_in;
   logic signed [16:0] p1s;
   logic [20:0]        pp;
   logic [63:0]        s8_np_in;
   logic [31:0]        bsum;
   logic signed [17:0] hb;
   logic signed [34:0] v2_full;
   logic [63:0]        s8_m_ff;
   logic signed [63:0] s8_np_ff;
   logic [31:0]        s8_v2_ff;
   logic [31:0]        s8_tout_ff;
   logic [2:0]         s8_flags_ff;

   always_comb begin
      p1s      = $signed({1'b0, p1});
      s8_m_in  = s7_v_ff * p1s;
      pp       = PRESS_BASE - {1'b0, s7_rp_ff};
      s8_np_in = {12'b0, pp, 31'b0} - s7_y_ff;
      bsum     = s7_mz_ff + HUM_B_ROUND;
      hb       = bsum[31:14];
      v2_full  = s7_ha_ff * hb;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s8_m_ff     <= s8_m_in;
         s8_np_ff    <= s8_np_in;
         s8_v2_ff    <= v2_full[31:0];
         s8_tout_ff  <= s7_tout_ff;
         s8_flags_ff <= s7_flags_ff;
      end
   end

   // stage 9
   logic signed [63:0] s9_num_in;
   logic signed [16:0] hs;
   logic signed [33:0] ss_full;
   logic [30:0]        s9_den_ff;
   logic [63:0]        s9_num_ff;
   logic [31:0]        s9_v2_ff, s9_ss_ff;
   logic [31:0]        s9_tout_ff;
   logic [2:0]         s9_flags_ff;

   always_comb begin
      s9_num_in = s8_np_ff * PRESS_SCALE;
      hs        = s8_v2_ff[31:15];
      ss_full   = hs * hs;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s9_den_ff   <= s8_m_ff[63:33];
         s9_num_ff   <= s9_num_in;
         s9_v2_ff    <= s8_v2_ff;
         s9_ss_ff    <= ss_full[31:0];
         s9_tout_ff  <= s8_tout_ff;
         s9_flags_ff <= s8_flags_ff;
      end
   end

   // stage 10: magnitudes for the divider
   logic [63:0]        s10_nabs_in;
   logic [30:0]        s10_dabs_in;
   logic signed [24:0] hs2;
   logic signed [8:0]  h1s;
   logic signed [33:0] sh_full;
   logic [63:0]        s10_nabs_ff;
   logic [30:0]        s10_dabs_ff;
   logic               s10_neg_ff, s10_zero_ff;
   logic [31:0]        s10_v2_ff, s10_sh_ff;
   logic [31:0]        s10_tout_ff;
   logic [2:0]         s10_flags_ff;

   always_comb begin
      s10_nabs_in = s9_num_ff[63] ? (64'd0 - s9_num_ff) : s9_num_ff;
      s10_dabs_in = s9_den_ff[30] ? (31'd0 - s9_den_ff) : s9_den_ff;
      hs2         = s9_ss_ff[31:7];
      h1s         = $signed({1'b0, h1});
      sh_full     = hs2 * h1s;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s10_nabs_ff  <= s10_nabs_in;
         s10_dabs_ff  <= s10_dabs_in;
         s10_neg_ff   <= s9_num_ff[63] ^ s9_den_ff[30];
         s10_zero_ff  <= s9_den_ff == 31'd0;
         s10_v2_ff    <= s9_v2_ff;
         s10_sh_ff    <= sh_full[31:0];
         s10_tout_ff  <= s9_tout_ff;
         s10_flags_ff <= s9_flags_ff;
      end
   end

   // stage 11: humidity result
   logic signed [31:0] v3;
   logic [31:0]        vclamp;
   div_tag_type        s11_tag_in;
   logic [63:0]        s11_nabs_ff;
   logic [30:0]        s11_dabs_ff;
   div_tag_type        s11_tag_ff;

   always_comb begin
      v3 = s10_v2_ff - {{4{s10_sh_ff[31]}}, s10_sh_ff[31:4]};
      if (v3[31]) begin
         vclamp = '0;
      end else if (v3 > HUM_CLAMP) begin
         vclamp = HUM_CLAMP;
      end else begin
         vclamp = v3;
      end
      s11_tag_in.neg                    = s10_neg_ff;
      s11_tag_in.zero                   = s10_zero_ff;
      s11_tag_in.side.temperature_centi = s10_tout_ff;
      s11_tag_in.side.skipped_flags     = s10_flags_ff;
      if (s10_flags_ff[2]) begin
         s11_tag_in.side.humidity_q22_10 = '0;
      end else begin
         s11_tag_in.side.humidity_q22_10 = vclamp[28:12];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s11_nabs_ff <= s10_nabs_ff;
         s11_dabs_ff <= s10_dabs_ff;
         s11_tag_ff  <= s11_tag_in;
      end
   end

   // pressure division
   logic [DIV_W-1:0] div_quo;
   div_tag_type      div_tag;

   pthc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (front_valid_ff[FRONT_STAGES-1]),
      .in_num    (s11_nabs_ff),
      .in_den    (s11_dabs_ff),
      .in_tag    (s11_tag_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // back stage 1: signed quotient
   logic signed [63:0] e1_q_ff;
   logic               e1_zero_ff;
   side_type           e1_side_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e1_q_ff    <= div_tag.neg ? (64'd0 - div_quo) : div_quo;
         e1_zero_ff <= div_tag.zero;
         e1_side_ff <= div_tag.side;
      end
   end

   // back stage 2: square of the scaled quotient in two halves
   logic signed [63:0] qt;
   logic [31:0]        qt_hi, qt_lo;
   logic [63:0]        e2_bb_in;
   logic [31:0]        e2_ab_in;
   logic signed [63:0] e2_p8q_in;
   logic signed [63:0] e2_q_ff, e2_p8q_ff;
   logic [63:0]        e2_bb_ff;
   logic [31:0]        e2_ab_ff;
   logic               e2_zero_ff;
   side_type           e2_side_ff;

   always_comb begin
      qt        = e1_q_ff >>> 13;
      qt_hi     = qt[63:32];
      qt_lo     = qt[31:0];
      e2_bb_in  = qt_lo * qt_lo;
      e2_ab_in  = qt_hi * qt_lo;
      e2_p8q_in = e1_q_ff * p8;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e2_q_ff    <= e1_q_ff;
         e2_bb_ff   <= e2_bb_in;
         e2_ab_ff   <= e2_ab_in;
         e2_p8q_ff  <= e2_p8q_in;
         e2_zero_ff <= e1_zero_ff;
         e2_side_ff <= e1_side_ff;
      end
   end

   // back stage 3
   logic signed [63:0] e3_q_ff, e3_tt_ff, e3_y_ff;
   logic               e3_zero_ff;
   side_type           e3_side_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e3_q_ff    <= e2_q_ff;
         e3_tt_ff   <= e2_bb_ff + {e2_ab_ff[30:0], 33'b0};
         e3_y_ff    <= e2_p8q_ff >>> 19;
         e3_zero_ff <= e2_zero_ff;
         e3_side_ff <= e2_side_ff;
      end
   end

   // back stage 4
   logic signed [63:0] e4_w_in;
   logic signed [63:0] e4_q_ff, e4_w_ff, e4_y_ff;
   logic               e4_zero_ff;
   side_type           e4_side_ff;

   always_comb begin
      e4_w_in = e3_tt_ff * p9;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         e4_q_ff    <= e3_q_ff;
         e4_w_ff    <= e4_w_in;
         e4_y_ff    <= e3_y_ff;
         e4_zero_ff <= e3_zero_ff;
         e4_side_ff <= e3_side_ff;
      end
   end

   // output register
   logic signed [63:0] psum;
   logic [31:0]        p7_ext;
   logic [31:0]        out_press_in;
   logic [31:0]        out_press_ff;
   side_type           out_side_ff;

   always_comb begin
      psum   = e4_q_ff + (e4_w_ff >>> 25) + e4_y_ff;
      p7_ext = {{16{p7[15]}}, p7};
      if (e4_zero_ff || e4_side_ff.skipped_flags[1]) begin
         out_press_in = '0;
      end else begin
         out_press_in = psum[39:8] + (p7_ext << 4);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         out_press_ff <= out_press_in;
         out_side_ff  <= e4_side_ff;
      end
   end

   assign rsp_temperature_centi = out_side_ff.temperature_centi;
   assign rsp_pressure_q24_8    = out_press_ff;
   assign rsp_humidity_q22_10   = out_side_ff.humidity_q22_10;
   assign rsp_skipped_flags     = out_side_ff.skipped_flags;

   a_temp_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped_flags[0] |-> rsp_temperature_centi == 32'sd0)
      else $error("skipped temperature not zero");

   a_press_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped_flags[1] |-> rsp_pressure_q24_8 == 32'd0)
      else $error("skipped pressure not zero");

   a_hum_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped_flags[2] |-> rsp_humidity_q22_10 == 17'd0)
      else $error("skipped humidity not zero");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_q22_10 <= HUM_MAX)
      else $error("humidity above clamp");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(front_valid_ff) && $stable(back_valid_ff))
      else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

// File: tb/pth_sensor_compensation_checker.sv
// Checker for the compensation unit: tracks trim writes on the csr port, predicts
// each accepted item's result and compares it with the rsp channel. Depends on pthc_pkg.
`default_nettype none

module pth_sensor_compensation_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [19:0] req_raw_temperature,
   input  wire logic [19:0] req_raw_pressure,
   input  wire logic [15:0] req_raw_humidity,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [31:0] rsp_temperature_centi,
   input  wire logic [31:0] rsp_pressure_q24_8,
   input  wire logic [16:0] rsp_humidity_q22_10,
   input  wire logic [2:0]  rsp_skipped_flags,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_pready,
   input  wire logic [pthc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [pthc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int               failures,
   output int               outstanding,
   output int               compared
);
   import pthc_pkg::*;

   typedef struct packed {
      logic [31:0] temperature_centi;
      logic [31:0] pressure_q24_8;
      logic [16:0] humidity_q22_10;
      logic [2:0]  skipped_flags;
   } reading_type;

   logic [47:0] temp_trim;
   logic [63:0] press_trim_a, press_trim_b, hum_trim;
   logic [15:0] press_trim_c;
   reading_type expected_readings[$];

   function automatic longint wrap32(longint v);
      int t;
      t = v[31:0];
      return longint'(t);
   endfunction

   function automatic longint fine_temperature(longint adc);
      longint t1, t2, t3, d1, a, d2, sq, b;
      t1 = longint'(temp_trim[15:0]);
      t2 = longint'($signed(temp_trim[31:16]));
      t3 = longint'($signed(temp_trim[47:32]));
      d1 = (adc >>> 3) - t1 * 2;
      a = wrap32(d1 * t2) >>> 11;
      d2 = (adc >>> 4) - t1;
      sq = wrap32(d2 * d2) >>> 12;
      b = wrap32(sq * t3) >>> 14;
      return wrap32(a + b);
   endfunction

   function automatic logic [31:0] pressure_pa(longint tf, longint adc);
      longint p1, p2, p3, p4, p5, p6, p7, p8, p9, x, y, p, num, q;
      p1 = longint'(press_trim_a[15:0]);
      p2 = longint'($signed(press_trim_a[31:16]));
      p3 = longint'($signed(press_trim_a[47:32]));
      p4 = longint'($signed(press_trim_a[63:48]));
      p5 = longint'($signed(press_trim_b[15:0]));
      p6 = longint'($signed(press_trim_b[31:16]));
      p7 = longint'($signed(press_trim_b[47:32]));
      p8 = longint'($signed(press_trim_b[63:48]));
      p9 = longint'($signed(press_trim_c));
      x = tf - 128000;
      y = x * x * p6;
      y = y + ((x * p5) <<< 17);
      y = y + (p4 <<< 35);
      x = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
      x = (((64'sd1 <<< 47) + x) * p1) >>> 33;
      if (x == 0) return 32'd0;
      p = 1048576 - adc;
      num = ((p <<< 31) - y) * 3125;
      if (x == -1) q = -num;
      else q = num / x;
      x = (p9 * (q >>> 13) * (q >>> 13)) >>> 25;
      y = (p8 * q) >>> 19;
      q = ((q + x + y) >>> 8) + (p7 <<< 4);
      return q[31:0];
   endfunction

   function automatic logic [16:0] humidity_rh(longint tf, longint adc);
      longint h1, h2, h3, h4, h5, h6, v, a, x, y, z, b, s;
      h1 = longint'(hum_trim[7:0]);
      h2 = longint'($signed(hum_trim[23:8]));
      h3 = longint'(hum_trim[31:24]);
      h4 = longint'($signed(hum_trim[43:32]));
      h5 = longint'($signed(hum_trim[55:44]));
      h6 = longint'($signed(hum_trim[63:56]));
      v = wrap32(tf - 76800);
      a = wrap32(wrap32(adc * 16384) - wrap32(h4 * 1048576));
      a = wrap32(a - wrap32(h5 * v));
      a = wrap32(a + 16384) >>> 15;
      x = wrap32(v * h6) >>> 10;
      y = wrap32((wrap32(v * h3) >>> 11) + 32768);
      z = wrap32((wrap32(x * y) >>> 10) + 2097152);
      b = wrap32(wrap32(z * h2) + 8192) >>> 14;
      v = wrap32(a * b);
      s = v >>> 15;
      s = wrap32(s * s) >>> 7;
      s = wrap32(s * h1) >>> 4;
      v = wrap32(v - s);
      if (v < 0) v = 0;
      if (v > 419430400) v = 419430400;
      v = v >>> 12;
      return v[16:0];
   endfunction

   function automatic reading_type compensate(logic [19:0] rt, logic [19:0] rp,
                                               logic [15:0] rh);
      reading_type r;
      longint tf, t;
      r = '0;
      tf = fine_temperature(longint'(rt));
      if (rt == TEMP_SKIP) r.skipped_flags[0] = 1'b1;
      else begin
         t = wrap32(wrap32(tf * 5) + 128) >>> 8;
         r.temperature_centi = t[31:0];
      end
      if (rp == PRESS_SKIP) r.skipped_flags[1] = 1'b1;
      else r.pressure_q24_8 = pressure_pa(tf, longint'(rp));
      if (rh == HUM_SKIP) r.skipped_flags[2] = 1'b1;
      else r.humidity_q22_10 = humidity_rh(tf, longint'(rh));
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type e;
      if (reset) begin
         temp_trim <= '0;
         press_trim_a <= '0;
         press_trim_b <= '0;
         press_trim_c <= '0;
         hum_trim <= '0;
         failures = 0;
         compared = 0;
         expected_readings.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[5:3]))
               REG_TEMP_TRIM: temp_trim <= csr_pwdata[47:0];
               REG_PRESS_TRIM_A: press_trim_a <= csr_pwdata;
               REG_PRESS_TRIM_B: press_trim_b <= csr_pwdata;
               REG_PRESS_TRIM_C: press_trim_c <= csr_pwdata[15:0];
               REG_HUM_TRIM: hum_trim <= csr_pwdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               $error("result with no item pending");
               failures++;
            end else begin
               e = expected_readings.pop_front();
               compared++;
               if (rsp_temperature_centi !== e.temperature_centi) begin
                  $error("temperature_centi expected %0d actual %0d",
                         $signed(e.temperature_centi), $signed(rsp_temperature_centi));
                  failures++;
               end
               if (rsp_pressure_q24_8 !== e.pressure_q24_8) begin
                  $error("pressure_q24_8 expected %0h actual %0h",
                         e.pressure_q24_8, rsp_pressure_q24_8);
                  failures++;
               end
               if (rsp_humidity_q22_10 !== e.humidity_q22_10) begin
                  $error("humidity_q22_10 expected %0d actual %0d",
                         e.humidity_q22_10, rsp_humidity_q22_10);
                  failures++;
               end
               if (rsp_skipped_flags !== e.skipped_flags) begin
                  $error("skipped_flags expected %0b actual %0b",
                         e.skipped_flags, rsp_skipped_flags);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_readings.push_back(compensate(req_raw_temperature, req_raw_pressure,
                                                   req_raw_humidity));
      end
      outstanding = expected_readings.size();
   end
endmodule

`default_nettype wire

// File: tb/pth_sensor_compensation_unit_test.sv
// Top of the compensation unit testbench: clock, reset, trim writes and raw item stimulus.
// Depends on pthc_pkg, pth_sensor_compensation_unit and pth_sensor_compensation_checker.
`default_nettype none

module pth_sensor_compensation_unit_test;
   import pthc_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic [19:0] req_raw_temperature, req_raw_pressure;
   logic [15:0] req_raw_humidity;
   logic signed [31:0] rsp_temperature_centi;
   logic [31:0] rsp_pressure_q24_8;
   logic [16:0] rsp_humidity_q22_10;
   logic [2:0] rsp_skipped_flags;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   int failures, outstanding, compared, sent, cycles, stall_phase;
   logic [63:0] trim_set[5];

   pth_sensor_compensation_unit dut (.*);

   pth_sensor_compensation_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_raw_temperature, .req_raw_pressure,
      .req_raw_humidity, .rsp_valid, .rsp_stall, .rsp_temperature_centi,
      .rsp_pressure_q24_8, .rsp_humidity_q22_10, .rsp_skipped_flags, .csr_psel,
      .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .failures, .outstanding, .compared);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: alternate between free-running stretches and random stalls
   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 600;
      if (stall_phase < 150) rsp_stall <= 1'b0;
      else if (stall_phase < 400) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= ($urandom_range(0, 1) == 0);
   end

   task automatic write_trim(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {idx, 3'b000};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   task automatic load_trims();
      write_trim(REG_TEMP_TRIM, trim_set[0]);
      write_trim(REG_PRESS_TRIM_A, trim_set[1]);
      write_trim(REG_PRESS_TRIM_B, trim_set[2]);
      write_trim(REG_PRESS_TRIM_C, trim_set[3]);
      write_trim(REG_HUM_TRIM, trim_set[4]);
   endtask

   task automatic send_item(logic [19:0] rt, logic [19:0] rp, logic [15:0] rh);
      @(negedge clock);
      req_valid = 1'b1;
      req_raw_temperature = rt;
      req_raw_pressure = rp;
      req_raw_humidity = rh;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic hold_off(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   task automatic drain();
      hold_off(1);
      wait (outstanding == 0);
      hold_off(100);
   endtask

   task automatic send_random_burst(int count);
      logic [19:0] rt, rp;
      logic [15:0] rh;
      int burst;
      burst = 0;
      repeat (count) begin
         rt = 20'($urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(400000, 600000));
         rp = 20'($urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(250000, 450000));
         rh = 16'($urandom_range(0, 15) == 0 ? $urandom() : $urandom_range(20000, 45000));
         if ($urandom_range(0, 30) == 0) rt = TEMP_SKIP;
         if ($urandom_range(0, 30) == 0) rp = PRESS_SKIP;
         if ($urandom_range(0, 30) == 0) rh = HUM_SKIP;
         send_item(rt, rp, rh);
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            hold_off($urandom_range(0, 8));
         end else burst--;
      end
   endtask

   initial begin
      cycles = 0;
      sent = 0;
      stall_phase = 0;
      rsp_stall = 1'b0;
      req_valid = 1'b0;
      req_raw_temperature = '0;
      req_raw_pressure = '0;
      req_raw_humidity = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // typical part trims
      trim_set[0] = {16'hFC18, 16'd26435, 16'd27504};
      trim_set[1] = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
      trim_set[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
      trim_set[3] = 64'd6000;
      trim_set[4] = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};
      load_trims();

      send_item(20'h00000, 20'h00000, 16'h0000);
      send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
      send_item(20'h80000, 20'h5A000, 16'h6500);
      send_item(20'h7E000, 20'h80000, 16'h6500);
      send_item(20'h7E000, 20'h5A000, 16'h8000);
      send_item(20'h80000, 20'h80000, 16'h8000);
      send_item(20'h7FFFF, 20'h80001, 16'h7FFF);
      send_item(20'h80001, 20'h7FFFF, 16'h8001);
      send_item(20'h7E000, 20'h00001, 16'h0001);
      send_item(20'h00001, 20'hFFFFE, 16'hFFFE);
      send_item(20'h7E000, 20'h5A000, 16'h6500);
      send_item(20'h10000, 20'h20000, 16'h2000);
      drain();

      // zero trims: pressure divisor is zero
      foreach (trim_set[i]) trim_set[i] = '0;
      load_trims();
      send_item(20'h7E000, 20'h5A000, 16'h6500);
      send_item(20'hFFFFF, 20'h00000, 16'hFFFF);
      send_random_burst(150);
      drain();

      // all-ones trims
      foreach (trim_set[i]) trim_set[i] = '1;
      load_trims();
      send_item(20'h00000, 20'hFFFFF, 16'h0000);
      send_random_burst(150);
      drain();

      // extreme signed coefficients
      trim_set[0] = {16'h8000, 16'h7FFF, 16'hFFFF};
      trim_set[1] = {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF};
      trim_set[2] = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      trim_set[3] = 64'h8000;
      trim_set[4] = {8'h80, 12'h7FF, 12'h800, 8'hFF, 16'h7FFF, 8'hFF};
      load_trims();
      send_random_burst(150);
      drain();

      repeat (4) begin
         foreach (trim_set[i]) trim_set[i] = {$urandom(), $urandom()};
         load_trims();
         send_random_burst(150);
         drain();
      end

      trim_set[0] = {16'hFC18, 16'd26435, 16'd27504};
      trim_set[1] = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
      trim_set[2] = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
      trim_set[3] = 64'd6000;
      trim_set[4] = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};
      load_trims();
      send_random_burst(240);
      hold_off(1);
      wait (outstanding == 0);
      send_random_burst(240);
      drain();

      $display("Sent %0d raw sets over nine trim loads; %0d results compared.",
               sent, compared);
      if (failures == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

`default_nettype wire
